FILE: sv/lskc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Longest subsequence with bounded value changes: shared package
// Payload structs and sequencer states used by the block and its tests.
// ----------------------------------------------------------------------------
package lskc_pkg;

	typedef struct packed {
		logic [31:0] sample_value;
		logic        start_sequence;
	} sample_t;

	typedef struct packed {
		logic [15:0] best_length;
		logic        table_overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCMP,
		ST_TOP,
		ST_STEP_RD,
		ST_STEP_WR,
		ST_OUT_RD,
		ST_OUT_WR
	} state_t;

endpackage
`default_nettype wire

FILE: sv/lskc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lskc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: sv/longest_subsequence_k_changes_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Longest subsequence with bounded value changes
// Streaming dynamic program over a table of distinct values.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result with the longest subsequence length
// so far in which at most max_changes neighboring pairs differ. The block
// handles one sample at a time. The key lookup reads the key memory slot by
// slot over the filled slots (ST_SCAN and ST_SCMP), then the dynamic-program
// walk runs ST_STEP_RD and ST_STEP_WR once per change count (k+1 steps for a
// known value, K_MAX+1 steps for a new one, which also zeroes its row), with
// ST_TOP before it and ST_OUT_RD and ST_OUT_WR after it. A value dropped on a
// full table goes from the scan straight to the output states.
// No clearing pass is needed after reset.
module longest_subsequence_k_changes_top #(
	parameter int DISTINCT_MAX = 256,
	parameter int K_MAX        = 63,
	parameter int LEN_BITS     = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [5:0]        cfg_data,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire lskc_pkg::sample_t sample,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output lskc_pkg::result_t      result
);

	localparam int SW   = $clog2(DISTINCT_MAX);
	localparam int CW   = $clog2(DISTINCT_MAX + 1);
	localparam int JW   = $clog2(K_MAX + 1);
	localparam int RD   = K_MAX + 2;
	localparam int RW   = $clog2(RD);
	localparam int ROW  = K_MAX + 1;
	localparam int LD   = DISTINCT_MAX * ROW;
	localparam int LA   = $clog2(LD);

	lskc_pkg::state_t state_q, state_d;

	logic [5:0]          mc_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic [SW-1:0]       slot_q;
	logic [JW-1:0]       j_q;
	logic [JW-1:0]       k_q;
	logic                new_q;
	logic                top_q;
	logic                ovf_q;
	logic [31:0]         value_q;
	logic [LEN_BITS-1:0] carry_q;
	logic [RD-1:0]       rmv_q;
	logic                rm_rv_q;
	logic                out_valid_q;
	lskc_pkg::result_t   out_data_q;

	logic                key_we;
	logic [31:0]         key_rdata;
	logic                len_we;
	logic [LA-1:0]       len_addr;
	logic [LEN_BITS-1:0] len_wdata;
	logic [LEN_BITS-1:0] len_rdata;
	logic                rm_we;
	logic [RW-1:0]       rm_waddr;
	logic [RW-1:0]       rm_raddr;
	logic [LEN_BITS-1:0] rm_wdata;
	logic [LEN_BITS-1:0] rm_rdata;

	logic [LEN_BITS-1:0] e_old;
	logic [LEN_BITS-1:0] rm_j;
	logic [LEN_BITS-1:0] mx;
	logic [LEN_BITS-1:0] m_new;
	logic                beyond_k;
	logic                full;
	logic                at_end;
	logic                out_free;
	logic [JW-1:0]       k_new;

	assign cfg_ready    = 1'b1;
	assign sample_stall = (state_q != lskc_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_data_q;

	assign full     = (count_q == CW'(DISTINCT_MAX));
	assign at_end   = (idx_q == count_q);
	assign out_free = !out_valid_q || !result_stall;
	assign k_new    = (32'(mc_q) > K_MAX) ? JW'(K_MAX) : JW'(mc_q);

	assign e_old    = new_q ? '0 : len_rdata;
	assign rm_j     = rm_rv_q ? rm_rdata : '0;
	assign mx       = (e_old > rm_j) ? e_old : rm_j;
	assign m_new    = (&mx) ? mx : mx + 1'b1;
	assign beyond_k = (j_q > k_q);

	lskc_ram #(.WIDTH(32), .DEPTH(DISTINCT_MAX)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (count_q[SW-1:0]),
		.wdata (value_q),
		.raddr (idx_q[SW-1:0]),
		.rdata (key_rdata)
	);

	lskc_ram #(.WIDTH(LEN_BITS), .DEPTH(LD)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_addr),
		.wdata (len_wdata),
		.raddr (len_addr),
		.rdata (len_rdata)
	);

	lskc_ram #(.WIDTH(LEN_BITS), .DEPTH(RD)) u_rm_ram (
		.clk   (clk),
		.we    (rm_we),
		.waddr (rm_waddr),
		.wdata (rm_wdata),
		.raddr (rm_raddr),
		.rdata (rm_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lskc_pkg::ST_IDLE: begin
				if (sample_valid) begin
					state_d = lskc_pkg::ST_SCAN;
				end
			end
			lskc_pkg::ST_SCAN: begin
				priority if (!at_end) begin
					state_d = lskc_pkg::ST_SCMP;
				end else if (!full) begin
					state_d = lskc_pkg::ST_TOP;
				end else begin
					state_d = lskc_pkg::ST_OUT_RD;
				end
			end
			lskc_pkg::ST_SCMP: begin
				state_d = (key_rdata == value_q) ? lskc_pkg::ST_TOP : lskc_pkg::ST_SCAN;
			end
			lskc_pkg::ST_TOP: begin
				state_d = lskc_pkg::ST_STEP_RD;
			end
			lskc_pkg::ST_STEP_RD: begin
				state_d = lskc_pkg::ST_STEP_WR;
			end
			lskc_pkg::ST_STEP_WR: begin
				state_d = (j_q == '0) ? lskc_pkg::ST_OUT_RD : lskc_pkg::ST_STEP_RD;
			end
			lskc_pkg::ST_OUT_RD: begin
				state_d = lskc_pkg::ST_OUT_WR;
			end
			lskc_pkg::ST_OUT_WR: begin
				if (out_free) begin
					state_d = lskc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lskc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		key_we    = 1'b0;
		len_we    = 1'b0;
		len_addr  = LA'(slot_q) * LA'(ROW) + LA'(j_q);
		len_wdata = beyond_k ? '0 : m_new;
		rm_we     = 1'b0;
		rm_waddr  = RW'(j_q) + 1'b1;
		rm_wdata  = (carry_q > m_new) ? carry_q : m_new;
		rm_raddr  = '0;
		unique case (state_q)
			lskc_pkg::ST_SCAN: begin
				key_we = at_end && !full;
			end
			lskc_pkg::ST_TOP: begin
				rm_raddr = RW'(j_q) + 1'b1;
			end
			lskc_pkg::ST_STEP_RD: begin
				rm_raddr = RW'(j_q);
			end
			lskc_pkg::ST_STEP_WR: begin
				len_we = 1'b1;
				rm_we  = !beyond_k;
			end
			lskc_pkg::ST_OUT_RD, lskc_pkg::ST_OUT_WR: begin
				rm_raddr = RW'(k_q) + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lskc_pkg::ST_IDLE;
			mc_q        <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			rmv_q       <= '0;
			rm_rv_q     <= 1'b0;
			out_valid_q <= 1'b0;
			top_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			rm_rv_q <= rmv_q[rm_raddr];
			if (cfg_valid && cfg_ready) begin
				mc_q <= cfg_data;
			end
			if (out_valid_q && !result_stall && state_q != lskc_pkg::ST_OUT_WR) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				lskc_pkg::ST_IDLE: begin
					if (sample_valid) begin
						value_q <= sample.sample_value;
						k_q     <= k_new;
						idx_q   <= '0;
						if (sample.start_sequence) begin
							count_q <= '0;
							rmv_q   <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				lskc_pkg::ST_SCAN: begin
					if (at_end) begin
						if (!full) begin
							slot_q  <= count_q[SW-1:0];
							count_q <= count_q + 1'b1;
							new_q   <= 1'b1;
							j_q     <= JW'(K_MAX);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				lskc_pkg::ST_SCMP: begin
					if (key_rdata == value_q) begin
						slot_q <= idx_q[SW-1:0];
						new_q  <= 1'b0;
						j_q    <= k_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				lskc_pkg::ST_TOP: begin
					top_q <= 1'b1;
				end
				lskc_pkg::ST_STEP_RD: begin
					if (top_q) begin
						carry_q <= rm_rv_q ? rm_rdata : '0;
						top_q   <= 1'b0;
					end
				end
				lskc_pkg::ST_STEP_WR: begin
					carry_q <= rm_j;
					if (!beyond_k) begin
						rmv_q[rm_waddr] <= 1'b1;
					end
					if (j_q != '0) begin
						j_q <= j_q - 1'b1;
					end
				end
				lskc_pkg::ST_OUT_WR: begin
					if (out_free) begin
						out_valid_q               <= 1'b1;
						out_data_q.best_length    <= 16'(rm_rv_q ? rm_rdata : '0);
						out_data_q.table_overflow <= ovf_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DISTINCT_MAX))
		else $error("slot count exceeds table depth");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == lskc_pkg::ST_OUT_WR))
		else $error("result appeared outside the output state");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> full)
		else $error("overflow flagged with free slots");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lskc_pkg::ST_STEP_WR && !new_q) |-> !beyond_k)
		else $error("known value walk started above change limit");
`endif

endmodule
`default_nettype wire
